### sv/spq_pkg.sv
`timescale 1ns / 1ps
// spq_pkg: action and status codes of the sorted priority queue
// no dependencies; used by the top level and the checker

package spq_pkg;

	typedef enum logic [2:0] {
		ACT_INSERT    = 3'd0,
		ACT_PEEK_HEAD = 3'd1,
		ACT_POP_HEAD  = 3'd2,
		ACT_PEEK_TAIL = 3'd3,
		ACT_POP_TAIL  = 3'd4,
		ACT_CLEAR     = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

endpackage

### sv/spq_req_if.sv
`timescale 1ns / 1ps
// spq_req_if: request channel of the sorted priority queue (action and value)
// no dependencies

interface spq_req_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic [2:0]                    action;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

### sv/spq_rsp_if.sv
`timescale 1ns / 1ps
// spq_rsp_if: result channel of the sorted priority queue
// no dependencies; occupancy width follows from the capacity

interface spq_rsp_if #(
	parameter int VALUE_WIDTH = 32,
	parameter int CAPACITY    = 16
);
	localparam int OCC_W = $clog2(CAPACITY + 1);

	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] read_value;
	logic [1:0]                    status;
	logic [OCC_W-1:0]              occupancy;

	modport source (output valid, output read_value, output status, output occupancy,
		input ready);
	modport sink (input valid, input read_value, input status, input occupancy,
		output ready);
endinterface

### sv/spq_cfg_if.sv
`timescale 1ns / 1ps
// spq_cfg_if: configuration write channel, carries the sort direction bit
// no dependencies

interface spq_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// sorted_priority_queue_unit: double-ended priority queue kept as a sorted register row
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_cfg_if
// the result is registered in the output register when its item is accepted
// throughput: one item per cycle while results are taken, set by the parallel compare and one-place shift of the row
// ready drops only while a result is held in the output register and not taken
// reset clears the entry count, the sort direction and the result valid; entries are not reset

module sorted_priority_queue_unit #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp,
	spq_cfg_if.sink   cfg
);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	logic signed [VALUE_WIDTH-1:0] entry_q [CAPACITY];
	logic [CNT_W-1:0]              count_q;
	logic                          desc_q;

	logic                          rsp_valid_q;
	logic signed [VALUE_WIDTH-1:0] read_value_q;
	logic [1:0]                    status_q;
	logic [CNT_W-1:0]              occupancy_q;

	logic                          accept;
	logic                          empty;
	logic                          full;
	logic [CNT_W-1:0]              count_m1;
	logic signed [VALUE_WIDTH-1:0] tail_value;
	logic [CAPACITY-1:0]           take;

	logic [CNT_W-1:0]              nxt_count;
	logic signed [VALUE_WIDTH-1:0] nxt_read;
	spq_pkg::status_t              nxt_status;
	logic                          do_insert;
	logic                          do_pop_head;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign empty      = (count_q == '0);
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign count_m1   = count_q - CNT_W'(1);
	assign tail_value = entry_q[count_m1[IDX_W-1:0]];

	// per cell: insert position mask, then the cell's next value
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                          below;
		logic                          beats;
		logic signed [VALUE_WIDTH-1:0] shift_in;
		logic signed [VALUE_WIDTH-1:0] pop_in;

		assign below = (CNT_W'(g) < count_q);
		assign beats = desc_q ? (req.value >= entry_q[g]) : (req.value <= entry_q[g]);

		// mask runs from the first stored cell the value beats up to count, so a row
		// kept in the other direction still inserts at the first match
		if (g == 0) begin : g_first
			assign take[g]  = (CNT_W'(g) == count_q) || (below && beats);
			assign shift_in = req.value;
		end else begin : g_rest
			assign take[g]  = (CNT_W'(g) == count_q) || (below && (beats || take[g-1]));
			assign shift_in = take[g-1] ? entry_q[g-1] : req.value;
		end

		if (g == CAPACITY - 1) begin : g_last
			assign pop_in = entry_q[g];
		end else begin : g_inner
			assign pop_in = entry_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (accept && do_insert && take[g]) begin
				entry_q[g] <= shift_in;
			end else if (accept && do_pop_head) begin
				entry_q[g] <= pop_in;
			end
		end
	end

	always_comb begin
		nxt_count   = count_q;
		nxt_read    = '0;
		nxt_status  = spq_pkg::STATUS_OK;
		do_insert   = 1'b0;
		do_pop_head = 1'b0;
		case (req.action)
			spq_pkg::ACT_INSERT: begin
				if (full) begin
					nxt_status = spq_pkg::STATUS_FULL;
				end else begin
					do_insert = 1'b1;
					nxt_count = count_q + CNT_W'(1);
				end
			end
			spq_pkg::ACT_PEEK_HEAD, spq_pkg::ACT_POP_HEAD: begin
				if (empty) begin
					nxt_status = spq_pkg::STATUS_EMPTY;
				end else begin
					nxt_read = entry_q[0];
					if (req.action == spq_pkg::ACT_POP_HEAD) begin
						do_pop_head = 1'b1;
						nxt_count   = count_m1;
					end
				end
			end
			spq_pkg::ACT_PEEK_TAIL, spq_pkg::ACT_POP_TAIL: begin
				if (empty) begin
					nxt_status = spq_pkg::STATUS_EMPTY;
				end else begin
					nxt_read = tail_value;
					if (req.action == spq_pkg::ACT_POP_TAIL) begin
						nxt_count = count_m1;
					end
				end
			end
			spq_pkg::ACT_CLEAR: begin
				nxt_count = '0;
			end
			default: begin
				// unused codes leave everything as it is
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			desc_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				desc_q <= cfg.data;
			end
			if (accept) begin
				count_q     <= nxt_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= nxt_read;
			status_q     <= nxt_status;
			occupancy_q  <= nxt_count;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.occupancy  = occupancy_q;

endmodule

### sv/spq_checker.sv
`timescale 1ns / 1ps
// spq_checker: port-level checks of the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_unit

module spq_checker #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 req_valid,
	input logic                                 req_ready,
	input logic [2:0]                           req_action,
	input logic                                 rsp_valid,
	input logic                                 rsp_ready,
	input logic signed [VALUE_WIDTH-1:0]        rsp_read_value,
	input logic [1:0]                           rsp_status,
	input logic [$clog2(CAPACITY + 1)-1:0]      rsp_occupancy
);
	localparam int OCC_W = $clog2(CAPACITY + 1);

	// a result not taken stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == spq_pkg::STATUS_FULL |-> rsp_occupancy == OCC_W'(CAPACITY))
		else $error("full status with list not full");

	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == spq_pkg::STATUS_EMPTY
		|-> rsp_occupancy == '0 && rsp_read_value == '0)
		else $error("empty status with entries or read data");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_occupancy <= OCC_W'(CAPACITY))
		else $error("occupancy above capacity");

	// clear shows up in the very next result
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_action == spq_pkg::ACT_CLEAR
		|=> rsp_valid && rsp_occupancy == '0 && rsp_status == spq_pkg::STATUS_OK)
		else $error("clear did not empty the list");

endmodule

bind sorted_priority_queue_unit spq_checker #(
	.CAPACITY    (CAPACITY),
	.VALUE_WIDTH (VALUE_WIDTH)
) u_spq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_action     (req.action),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_status     (rsp.status),
	.rsp_occupancy  (rsp.occupancy)
);

### test/spq_order_check.sv
`timescale 1ns / 1ps
// spq_order_check: watches the request, result and direction channels of the sorted priority queue
// keeps its own sorted row and compares every result in order; depends on spq_pkg and the channel interfaces

module spq_order_check #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	spq_req_if   req,
	spq_rsp_if   rsp,
	spq_cfg_if   cfg,
	output int   fail_count,
	output int   pending,
	output int   results_seen,
	output int   full_seen,
	output int   empty_seen
);
	localparam int OCC_W = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] read_value;
		spq_pkg::status_t              status;
		logic [OCC_W-1:0]              occupancy;
	} queue_result_t;

	logic signed [VALUE_WIDTH-1:0] row [CAPACITY];
	int                            row_count;
	logic                          largest_first;
	queue_result_t                 expected_q[$];
	queue_result_t                 got, want;
	int                            n_fail, n_results, n_full, n_empty;

	// one action on the private copy of the row, returns the result it must give
	function automatic queue_result_t apply_action(input logic [2:0] act,
			input logic signed [VALUE_WIDTH-1:0] v);
		queue_result_t r;
		int            pos;
		r.read_value = '0;
		r.status     = spq_pkg::STATUS_OK;
		case (act)
			spq_pkg::ACT_INSERT: begin
				if (row_count >= CAPACITY) begin
					r.status = spq_pkg::STATUS_FULL;
				end else begin
					pos = row_count;
					for (int i = 0; i < row_count; i++) begin
						if (largest_first ? (v >= row[i]) : (v <= row[i])) begin
							pos = i;
							break;
						end
					end
					for (int i = row_count; i > pos; i--)
						row[i] = row[i-1];
					row[pos] = v;
					row_count++;
				end
			end
			spq_pkg::ACT_PEEK_HEAD, spq_pkg::ACT_POP_HEAD: begin
				if (row_count == 0) begin
					r.status = spq_pkg::STATUS_EMPTY;
				end else begin
					r.read_value = row[0];
					if (act == spq_pkg::ACT_POP_HEAD) begin
						for (int i = 1; i < row_count; i++)
							row[i-1] = row[i];
						row_count--;
					end
				end
			end
			spq_pkg::ACT_PEEK_TAIL, spq_pkg::ACT_POP_TAIL: begin
				if (row_count == 0) begin
					r.status = spq_pkg::STATUS_EMPTY;
				end else begin
					r.read_value = row[row_count-1];
					if (act == spq_pkg::ACT_POP_TAIL)
						row_count--;
				end
			end
			spq_pkg::ACT_CLEAR: begin
				row_count = 0;
			end
			default: ;
		endcase
		r.occupancy = row_count[OCC_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count     = 0;
			largest_first = 1'b0;
			expected_q.delete();
			n_fail        = 0;
			n_results     = 0;
			n_full        = 0;
			n_empty       = 0;
			fail_count   <= 0;
			pending      <= 0;
			results_seen <= 0;
			full_seen    <= 0;
			empty_seen   <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				largest_first = cfg.data;
			// predict before comparing so a same-edge result would still find its item
			if (req.valid && req.ready)
				expected_q.push_back(apply_action(req.action, req.value));
			if (rsp.valid && rsp.ready) begin
				got.read_value = rsp.read_value;
				got.status     = spq_pkg::status_t'(rsp.status);
				got.occupancy  = rsp.occupancy;
				n_results++;
				if (expected_q.size() == 0) begin
					if (n_fail < 10)
						$display("%0t: unexpected result value %0d status %0d occupancy %0d",
							$time, got.read_value, got.status, got.occupancy);
					n_fail++;
				end else begin
					want = expected_q.pop_front();
					if (want.status == spq_pkg::STATUS_FULL)
						n_full++;
					if (want.status == spq_pkg::STATUS_EMPTY)
						n_empty++;
					if (got.read_value !== want.read_value || got.status !== want.status ||
							got.occupancy !== want.occupancy) begin
						if (n_fail < 10)
							$display({"%0t: mismatch value %0d/%0d status %0d/%0d ",
								"occupancy %0d/%0d (exp/got)"},
								$time, want.read_value, got.read_value, want.status,
								got.status, want.occupancy, got.occupancy);
						n_fail++;
					end
				end
			end
			fail_count   <= n_fail;
			pending      <= expected_q.size();
			results_seen <= n_results;
			full_seen    <= n_full;
			empty_seen   <= n_empty;
		end
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives directed and random queue traffic with random gaps and stalls on both sides
// depends on spq_pkg, the channel interfaces, sorted_priority_queue_unit and spq_order_check

module tb_top;
	localparam int CAPACITY      = 16;
	localparam int VALUE_WIDTH   = 32;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 4;
	localparam int SEGMENTS      = 14;
	localparam int SEGMENT_ITEMS = 29;
	localparam int DIRECTED      = 21;

	// codes beyond the defined actions, expected to do nothing
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	logic clk;
	logic arst_n;
	logic no_idle;
	int   cycles = 0;
	int   fail_count, pending, results_seen, full_seen, empty_seen;

	spq_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req ();
	spq_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH), .CAPACITY(CAPACITY)) rsp ();
	spq_cfg_if cfg ();

	sorted_priority_queue_unit #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	spq_order_check #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) order_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.cfg          (cfg),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.full_seen    (full_seen),
		.empty_seen   (empty_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sorted_priority_queue_unit test failed");
			$finish;
		end
	end

	// result side: a random stall before each item is taken
	initial begin
		int stall;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
		end
	end

	task automatic send_item(input logic [2:0] act, input logic signed [VALUE_WIDTH-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid  <= 1'b1;
		req.action <= act;
		req.value  <= v;
		do @(posedge clk); while (!req.ready);
	endtask

	// stop sending and wait until every outstanding result has been taken
	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_direction(input logic largest_first);
		cfg.valid <= 1'b1;
		cfg.data  <= largest_first;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// extremes, zero and -1, small values for ties, otherwise anything
	function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VAL_MAX;
			1:       return VAL_MIN;
			2, 3:    return $signed($urandom_range(0, 16)) - 8;
			4:       return $urandom_range(0, 1) ? '0 : '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_action(input traffic_mode_t mode);
		int r;
		int insert_pct;
		r = $urandom_range(0, 99);
		if (r < 2)
			return $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
		if (r < 4)
			return spq_pkg::ACT_CLEAR;
		case (mode)
			MODE_FILL:  insert_pct = 85;
			MODE_DRAIN: insert_pct = 20;
			default:    insert_pct = 50;
		endcase
		if ($urandom_range(0, 99) < insert_pct)
			return spq_pkg::ACT_INSERT;
		case ($urandom_range(0, 3))
			0:       return spq_pkg::ACT_PEEK_HEAD;
			1:       return spq_pkg::ACT_POP_HEAD;
			2:       return spq_pkg::ACT_PEEK_TAIL;
			default: return spq_pkg::ACT_POP_TAIL;
		endcase
	endfunction

	initial begin
		logic [2:0]                    dir_act [DIRECTED];
		logic signed [VALUE_WIDTH-1:0] dir_val [DIRECTED];
		traffic_mode_t                 mode;
		int                            pick;

		arst_n     <= 1'b0;
		no_idle    <= 1'b0;
		req.valid  <= 1'b0;
		req.action <= spq_pkg::ACT_INSERT;
		req.value  <= '0;
		cfg.valid  <= 1'b0;
		cfg.data   <= 1'b0;

		// reads of an empty list, extremes and ties, head and tail access,
		// spare codes, clear twice, then a tail pop that empties a one-entry list
		dir_act = '{spq_pkg::ACT_PEEK_HEAD, spq_pkg::ACT_POP_HEAD, spq_pkg::ACT_PEEK_TAIL,
			spq_pkg::ACT_POP_TAIL,
			spq_pkg::ACT_INSERT, spq_pkg::ACT_INSERT, spq_pkg::ACT_INSERT,
			spq_pkg::ACT_INSERT, spq_pkg::ACT_INSERT, spq_pkg::ACT_INSERT,
			spq_pkg::ACT_PEEK_HEAD, spq_pkg::ACT_PEEK_TAIL, spq_pkg::ACT_POP_HEAD,
			spq_pkg::ACT_POP_TAIL,
			ACT_SPARE_6, ACT_SPARE_7, spq_pkg::ACT_CLEAR, spq_pkg::ACT_CLEAR,
			spq_pkg::ACT_INSERT, spq_pkg::ACT_POP_TAIL, spq_pkg::ACT_PEEK_HEAD};
		dir_val = '{'0, '1, '0, '1,
			VAL_MAX, VAL_MIN, '0, '1, VAL_MIN, VAL_MAX,
			'0, '0, '0, '0,
			VAL_MAX, VAL_MIN, '0, '0,
			32'sh5A5AA5A5, '0, '0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			set_direction(p[0]);
			if (p == 0) begin
				for (int i = 0; i < DIRECTED; i++)
					send_item(dir_act[i], dir_val[i]);
			end
			for (int s = 0; s < SEGMENTS; s++) begin
				pick = $urandom_range(0, 9);
				mode = (pick < 4) ? MODE_FILL : (pick < 7) ? MODE_DRAIN : MODE_MIXED;
				no_idle <= ($urandom_range(0, 3) == 0);
				for (int i = 0; i < SEGMENT_ITEMS; i++)
					send_item(pick_action(mode), pick_value());
			end
			// direction may change with entries still stored
			drain_results();
		end

		repeat (8) @(posedge clk);
		$display("checked %0d results in both sort orders: %0d refused inserts, %0d empty reads",
			results_seen, full_seen, empty_seen);
		if (fail_count == 0) begin
			$display("sorted_priority_queue_unit test passed");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("sorted_priority_queue_unit test failed");
		end
		$finish;
	end

endmodule

### filelist.f
sv/spq_pkg.sv
sv/spq_req_if.sv
sv/spq_rsp_if.sv
sv/spq_cfg_if.sv
sv/sorted_priority_queue_unit.sv
sv/spq_checker.sv
test/spq_order_check.sv
test/tb_top.sv
